>>> rtl/core/hcb_pkg.sv
// Shared types and constants for the Huffman code builder.
package hcb_pkg;
    localparam int MAX_LEAVES_DEF = 64;
    localparam int WEIGHT_W = 21;
    localparam int LEAF_W = 15;
    localparam int CODE_W = 63;
    localparam int LEN_W = 6;

    typedef struct packed {
        logic [14:0] leaf_weight;
        logic        last_leaf;
    } t_in_word;

    typedef struct packed {
        logic [5:0]  leaf_index;
        logic [5:0]  code_length;
        logic [62:0] code_bits;
        logic        last_code;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store incoming leaf weight
        logic init;        // begin build: first internal node, first leaf
        logic scan_first;  // reset scan index and running minima
        logic scan;        // read one node weight
        logic merge;       // write merged node weight and left child
        logic mark_a;      // mark left child used, write its parent
        logic mark_b;      // mark right child used, write its parent
        logic walk_start;  // begin code walk for one leaf
        logic walk_step;   // climb one level
        logic emit;        // drive a result word
        logic done;        // clear leaf count
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // leaf store full
        logic scan_end;    // last node of current scan addressed
        logic build_end;   // all internal nodes made
        logic at_root;     // walk reached root
        logic last_leaf_w; // current walk leaf is the final one
    } t_sts;
endpackage

>>> rtl/core/huffman_code_builder_unit.sv
// Huffman code builder top level: leaf load, tree build, code output.
// A leaf word without the last mark is stored and busy stays low,
// so such words can follow back to back; once MAX_LEAVES leaves are held,
// further weights are dropped. The word with the last mark raises busy for the
// build and the code output: an init step, then for each internal node i
// (n to 2n-2 for n leaves) a setup step, a scan of nodes 0 to i-1 at one node
// per cycle through the weight memory read port, a drain step and the merge,
// mark-left and mark-right writes, then a final step to finish the build.
// Each code word then comes from a walk from its leaf up to the root: a start
// step, then at each level a root test, a left-child read and a climb. Code
// words appear one per o_strobe pulse, the cycle after each code is ready, and
// cannot be held off; busy is low again during the strobe of the final code word.
module huffman_code_builder_unit #(
    parameter int MAX_LEAVES = hcb_pkg::MAX_LEAVES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  hcb_pkg::t_in_word  i_word,
    output logic               busy,
    output logic               o_strobe,
    output hcb_pkg::t_out_word o_word
);
    hcb_pkg::t_cmd      w_cmd;
    hcb_pkg::t_sts      w_sts;
    hcb_pkg::t_out_word w_word;
    hcb_pkg::t_out_word r_word;

    hcb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_last(i_word.last_leaf),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy), .o_strobe(o_strobe));

    hcb_datapath #(.MAX_LEAVES(MAX_LEAVES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_word(i_word),
        .o_sts(w_sts), .o_word(w_word));

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (w_cmd.emit) begin
            r_word <= w_word;
        end
    end
    assign o_word = r_word;
endmodule

>>> rtl/core/hcb_ram.sv
// Generic single-port-write, one-read RAM with registered read.
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/hcb_datapath.sv
// Datapath: node stores, min search, and code walk registers.
module hcb_datapath #(
    parameter int MAX_LEAVES = hcb_pkg::MAX_LEAVES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hcb_pkg::t_cmd      i_cmd,
    input  hcb_pkg::t_in_word  i_word,
    output hcb_pkg::t_sts      o_sts,
    output hcb_pkg::t_out_word o_word
);
    localparam int SLOTS = 2 * MAX_LEAVES - 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(MAX_LEAVES + 1);
    localparam int WW = hcb_pkg::WEIGHT_W;
    localparam logic [WW-1:0] TOP = '1;

    logic [CW-1:0]    r_cnt;
    logic [NW-1:0]    r_node;    // node being created
    logic [NW-1:0]    r_k;       // scan index
    logic [NW-1:0]    r_kd;      // index of data on RAM output
    logic             r_kv;      // scan data valid
    logic [WW-1:0]    r_lo1, r_lo2;
    logic [NW-1:0]    r_a, r_b;
    logic [NW-1:0]    r_leaf, r_cur;
    logic [hcb_pkg::LEN_W-1:0]  r_len;
    logic [hcb_pkg::CODE_W-1:0] r_bits;

    // Node word is {used, weight}; used means the node already has a parent.
    logic          w_full;
    logic          w_we;
    logic [NW-1:0] w_waddr;
    logic [WW:0]   w_wdata, w_q;
    logic          par_we;
    logic [NW-1:0] par_waddr, par_q, lc_q;
    logic [NW-1:0] w_nodes;

    assign w_full = (r_cnt == CW'(MAX_LEAVES));
    // 2n-1 nodes in the tree; the root is the last one made
    assign w_nodes = NW'({r_cnt, 1'b0} - (CW+1)'(1));

    // Node write: leaf load, merged node, then the two children marked used.
    always_comb begin
        w_we = 1'b0;
        w_waddr = NW'(r_cnt);
        w_wdata = {1'b0, {(WW-hcb_pkg::LEAF_W){1'b0}}, i_word.leaf_weight};
        if (i_cmd.load && !w_full) begin
            w_we = 1'b1;
        end else if (i_cmd.merge) begin
            w_we = 1'b1;
            w_waddr = r_node;
            w_wdata = {1'b0, r_lo1 + r_lo2};
        end else if (i_cmd.mark_a) begin
            w_we = 1'b1;
            w_waddr = r_a;
            w_wdata = {1'b1, r_lo1};
        end else if (i_cmd.mark_b) begin
            w_we = 1'b1;
            w_waddr = r_b;
            w_wdata = {1'b1, r_lo2};
        end
    end

    hcb_ram #(.WIDTH(WW + 1), .DEPTH(SLOTS)) u_wt (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_k), .o_rdata(w_q));

    // Parent and left-child memories; one write per cycle each.
    assign par_we = i_cmd.mark_a || i_cmd.mark_b;
    assign par_waddr = i_cmd.mark_b ? r_b : r_a;

    hcb_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(r_node),
        .i_raddr(r_cur), .o_rdata(par_q));
    // Walk: left child is read at the parent address straight off the parent RAM.
    hcb_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_lc (
        .i_clk(i_clk), .i_we(i_cmd.merge), .i_waddr(r_node), .i_wdata(r_a),
        .i_raddr(par_q), .o_rdata(lc_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_kv <= 1'b0;
        end else begin
            if (i_cmd.done) r_cnt <= '0;
            else if (i_cmd.load && !w_full) r_cnt <= r_cnt + CW'(1);
            r_kv <= i_cmd.scan;
        end
        if (i_cmd.init) r_node <= NW'(r_cnt);
        else if (i_cmd.mark_b) r_node <= r_node + NW'(1);
        if (i_cmd.scan_first) r_k <= '0;
        else if (i_cmd.scan) r_k <= r_k + NW'(1);
        if (i_cmd.scan) r_kd <= r_k;
        // Running two-minimum search, strict compare keeps lower index on ties.
        if (i_cmd.scan_first) begin
            r_lo1 <= TOP; r_lo2 <= TOP; r_a <= '0; r_b <= '0;
        end else if (r_kv && !w_q[WW]) begin
            if (w_q[WW-1:0] < r_lo1) begin
                r_lo2 <= r_lo1; r_b <= r_a; r_lo1 <= w_q[WW-1:0]; r_a <= r_kd;
            end else if (w_q[WW-1:0] < r_lo2) begin
                r_lo2 <= w_q[WW-1:0]; r_b <= r_kd;
            end
        end
        if (i_cmd.walk_start) begin
            r_cur <= r_leaf;
            r_len <= '0;
            r_bits <= '0;
        end else if (i_cmd.walk_step) begin
            if (lc_q != r_cur) r_bits <= r_bits | (hcb_pkg::CODE_W'(1) << r_len);
            r_len <= r_len + hcb_pkg::LEN_W'(1);
            r_cur <= par_q;
        end
        if (i_cmd.init) r_leaf <= '0;
        else if (i_cmd.emit) r_leaf <= r_leaf + NW'(1);
    end

    // Status and result word.
    always_comb begin
        o_sts.full = w_full;
        o_sts.scan_end = (r_k == r_node - NW'(1));
        o_sts.build_end = (r_node == w_nodes);
        o_sts.at_root = (r_cur == w_nodes - NW'(1));
        o_sts.last_leaf_w = (r_leaf == NW'(r_cnt) - NW'(1));
        o_word.leaf_index = hcb_pkg::LEN_W'(r_leaf);
        o_word.code_length = r_len;
        o_word.code_bits = r_bits;
        o_word.last_code = o_sts.last_leaf_w;
    end
endmodule

>>> rtl/core/hcb_ctrl.sv
// Controller: sequences load, tree build and code walk.
module hcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_last,
    input  hcb_pkg::t_sts i_sts,
    output hcb_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_strobe
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_WAIT, S_SCAN, S_SLAST, S_MERGE, S_MARK_A, S_MARK_B,
        S_WSTART, S_WTEST, S_WLC, S_WSTEP
    } t_state;
    t_state r_state;
    logic   r_strobe;

    // Commands decoded from the state.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
            end
            S_WAIT: begin
                o_cmd.scan_first = !i_sts.build_end;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
            end
            S_MARK_A: begin
                o_cmd.mark_a = 1'b1;
            end
            S_MARK_B: begin
                o_cmd.mark_b = 1'b1;
            end
            S_WSTART: begin
                o_cmd.walk_start = 1'b1;
            end
            S_WTEST: begin
                o_cmd.emit = i_sts.at_root;
                o_cmd.done = i_sts.at_root && i_sts.last_leaf_w;
            end
            S_WSTEP: begin
                o_cmd.walk_step = 1'b1;
            end
            default: begin
            end
        endcase
    end
    assign o_busy = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    // State and strobe register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start && i_last) r_state <= S_INIT;
                end
                S_INIT: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_sts.build_end) r_state <= S_WSTART;
                    else r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_sts.scan_end) r_state <= S_SLAST;
                end
                S_SLAST: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_state <= S_MARK_A;
                end
                S_MARK_A: begin
                    r_state <= S_MARK_B;
                end
                S_MARK_B: begin
                    r_state <= S_WAIT;
                end
                S_WSTART: begin
                    r_state <= S_WTEST;
                end
                S_WTEST: begin
                    if (i_sts.at_root) begin
                        r_strobe <= 1'b1;
                        r_state <= i_sts.last_leaf_w ? S_IDLE : S_WSTART;
                    end else begin
                        r_state <= S_WLC;
                    end
                end
                S_WLC: begin
                    r_state <= S_WSTEP;
                end
                S_WSTEP: begin
                    r_state <= S_WTEST;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/hcb_checker.sv
// Port-level checks for the Huffman code builder.
module hcb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input hcb_pkg::t_in_word  i_word,
    input logic               busy,
    input logic               o_strobe,
    input hcb_pkg::t_out_word o_word
);
    // no two code-word strobes come back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe two cycles in a row");
    // a leaf word without the last mark keeps the block idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_word.last_leaf |=> !busy) else $error("busy after leaf word");
    // the last mark starts a build
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_word.last_leaf |=> busy) else $error("no build after last word");
    // only the final code word shows while idle
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy == !o_word.last_code)) else $error("strobe and busy disagree");
endmodule

bind huffman_code_builder_unit hcb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_word(i_word), .busy(busy),
    .o_strobe(o_strobe), .o_word(o_word));
